// File: rtl/core/mireds_to_xy_planckian_locus_defines.svh
// Assertion macros shared by the checker of the Planckian locus block.
`ifndef MIREDS_TO_XY_PLANCKIAN_LOCUS_DEFINES_SVH
`define MIREDS_TO_XY_PLANCKIAN_LOCUS_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define M2XY_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define M2XY_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/core/m2xy_pkg.sv
// Package with the types, constants and fixed-point helper functions of the block.
`timescale 1ns / 1ps
package m2xy_pkg;
  localparam int unsigned MiredsLo = 40;
  localparam int unsigned MiredsHi = 599;
  localparam int unsigned Split4000K = 250;
  localparam int unsigned Split2222K = 451;
  localparam logic [15:0] XyMax = 16'hFEFF;
  localparam int unsigned QW = 36;
  // Mireds code that stands for everything cooler than 1667 K.
  localparam logic [9:0] MiredsCool = 10'd600;

  typedef enum logic [1:0] {
    BR_HIGH = 2'd0,
    BR_MID  = 2'd1,
    BR_LOW  = 2'd2
  } branch_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [9:0] mireds;
    logic       x_warm;
    branch_e    y_br;
  } item_t;

  // Decimal coefficient times 1e9 to Q format, rounding halves away from zero.
  function automatic logic signed [QW-1:0] dec_to_q(input longint c, input int frac);
    logic [63:0] mag;
    logic [63:0] r;
    begin
      mag = (c < 0) ? 64'(-c) : 64'(c);
      r = ((mag << frac) + 64'd500000000) / 64'd1000000000;
      dec_to_q = (c < 0) ? -QW'(r) : QW'(r);
    end
  endfunction

  // Coefficient k (0 = cubic term) of a table: 0 x_warm, 1 x_cool, 2 y_low, 3 y_mid, 4 y_high.
  function automatic longint coef(input int tbl, input int k);
    longint t [5][4];
    begin
      t[0] = '{-266123900, -234358900, 877695600, 179910000};
      t[1] = '{-64'sd3025846900, 2107037900, 222634700, 240390000};
      t[2] = '{-1106381400, -1348110200, 64'sd2185558320, -202196830};
      t[3] = '{-954947600, -1374185930, 2091370150, -167488670};
      t[4] = '{64'sd3081758000, -64'sd5873386700, 64'sd3751129970, -370014830};
      coef = t[tbl][k];
    end
  endfunction
endpackage

// File: rtl/core/mireds_to_xy_planckian_locus.sv
// Top level: mireds to CIE xy on the Planckian locus.
//  channel | direction | fields
//  in      | input     | temp_mireds_i
//  out     | output    | chroma_x_o, chroma_y_o
// One item per cycle sustained while the output is not stalled; each result passes through
// the queue register, then the multiply pipeline of Horner steps, then the output
// register.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// A stall on the output freezes the pipeline; the queue then fills and drops in_ready_o.
`timescale 1ns / 1ps
module mireds_to_xy_planckian_locus #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] temp_mireds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] chroma_x_o,
  output logic [15:0] chroma_y_o
);
  import m2xy_pkg::*;
  item_t f_item, q_item;
  logic  q_valid, q_ready;

  m2xy_front u_front (.temp_mireds_i(temp_mireds_i), .item_o(f_item));

  m2xy_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(f_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  m2xy_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o, .out_ready_i, .chroma_x_o, .chroma_y_o
  );
endmodule

// File: rtl/core/m2xy_front.sv
// Front part: clamps the temperature and picks the polynomial branches.
`timescale 1ns / 1ps
module m2xy_front (
  input  logic [15:0]         temp_mireds_i,
  output m2xy_pkg::item_t     item_o
);
  import m2xy_pkg::*;
  logic [15:0] m_eff;

  always_comb begin
    m_eff = (temp_mireds_i < 16'(MiredsLo)) ? 16'(MiredsLo) : temp_mireds_i;
    // Anything cooler than 1667 K maps to the cool code, which the back part treats as 1667 K.
    item_o.mireds = (m_eff > 16'(MiredsHi)) ? MiredsCool : m_eff[9:0];
    item_o.x_warm = (m_eff >= 16'(Split4000K));
    if (m_eff >= 16'(Split2222K)) begin
      item_o.y_br = BR_LOW;
    end else if (m_eff >= 16'(Split4000K)) begin
      item_o.y_br = BR_MID;
    end else begin
      item_o.y_br = BR_HIGH;
    end
  end
endmodule

// File: rtl/core/m2xy_fifo.sv
// Two-entry queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module m2xy_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  m2xy_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output m2xy_pkg::item_t out_item_o
);
  import m2xy_pkg::*;
  item_t mem_q [2];
  logic  wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end
endmodule

// File: rtl/core/m2xy_back.sv
// Back part: pipelined cubic evaluation of x in s and of y in x, with saturation.
`timescale 1ns / 1ps
module m2xy_back #(
  parameter int unsigned FracBits = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  m2xy_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     chroma_x_o,
  output logic [15:0]     chroma_y_o
);
  import m2xy_pkg::*;
  localparam int unsigned NStg = 8;
  localparam int unsigned PW = 2 * QW;
  localparam logic [PW-1:0] Half = PW'(1) << (FracBits - 1);

  // Stage 0 computes s, stages 1..3 the x Horner steps, 4..6 the y steps, and stage 7 is a
  // plain delay ahead of the saturating output register.
  logic [NStg-1:0] vld_q;
  logic            adv;
  logic signed [QW-1:0] acc_q [NStg];
  logic signed [QW-1:0] x_q   [4:NStg-1];
  logic signed [QW-1:0] s_q   [3];
  branch_e              br_q  [6];
  logic                 xw_q  [3];
  logic [15:0] cx_q, cy_q;
  logic        ov_q;

  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic [QW-1:0] ma, mb;
    logic [PW-1:0] p, r;
    begin
      ma = a[QW-1] ? -a : a;
      mb = b[QW-1] ? -b : b;
      p = PW'(ma) * PW'(mb);
      r = (p + Half) >> FracBits;
      qmul = (a[QW-1] != b[QW-1]) ? -QW'(r) : QW'(r);
    end
  endfunction

  function automatic logic signed [QW-1:0] xc(input logic warm, input int k);
    xc = warm ? dec_to_q(coef(0, k), FracBits) : dec_to_q(coef(1, k), FracBits);
  endfunction

  function automatic logic signed [QW-1:0] yc(input branch_e br, input int k);
    begin
      case (br)
        BR_LOW:  yc = dec_to_q(coef(2, k), FracBits);
        BR_MID:  yc = dec_to_q(coef(3, k), FracBits);
        default: yc = dec_to_q(coef(4, k), FracBits);
      endcase
    end
  endfunction

  function automatic logic [15:0] to_field(input logic signed [QW-1:0] q);
    logic [QW-1:0] u;
    begin
      u = QW'(q) >> (FracBits - 16);
      if (q <= 0) to_field = 16'd0;
      else if (u > QW'(XyMax)) to_field = XyMax;
      else to_field = u[15:0];
    end
  endfunction

  localparam logic [QW-1:0] SCool = QW'(((64'd1000 << FracBits) + 64'd833) / 64'd1667);
  // 2^F = SDivA * 1000 + SDivB, and SRecip = ceil(2^30 / 1000) divides any 20-bit value
  // by 1000 exactly after a shift by 30.
  localparam logic [QW-1:0] SDivA = QW'((64'd1 << FracBits) / 64'd1000);
  localparam logic [9:0]    SDivB = 10'((64'd1 << FracBits) % 64'd1000);
  localparam logic [20:0]   SRecip = 21'((64'd1 << 30) / 64'd1000 + 64'd1);

  // Advance the whole pipeline unless the output register holds an untaken result.
  assign adv = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  logic [19:0] s_rem;
  logic [40:0] s_rprod;
  logic [QW-1:0] s_calc;
  always_comb begin
    // s = round(m * 2^F / 1000) = m * SDivA + floor((m * SDivB + 500) / 1000).
    s_rem = 20'(in_item_i.mireds) * 20'(SDivB) + 20'd500;
    s_rprod = 41'(s_rem) * 41'(SRecip);
    s_calc = QW'(in_item_i.mireds) * SDivA + QW'(s_rprod[40:30]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
      ov_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= (in_item_i.mireds == MiredsCool) ? SCool : s_calc;
      xw_q[0] <= in_item_i.x_warm;
      br_q[0] <= in_item_i.y_br;
      acc_q[0] <= xc(in_item_i.x_warm, 0);
      for (int i = 1; i < 3; i++) begin
        s_q[i] <= s_q[i-1];
        xw_q[i] <= xw_q[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        br_q[i] <= br_q[i-1];
      end
      for (int i = 5; i < NStg; i++) begin
        x_q[i] <= x_q[i-1];
      end
      for (int i = 1; i <= 3; i++) begin
        acc_q[i] <= qmul(acc_q[i-1], s_q[i-1]) + xc(xw_q[i-1], i);
      end
      // Stage 4 latches x and starts the y Horner chain.
      x_q[4] <= acc_q[3];
      acc_q[4] <= qmul(yc(br_q[3], 0), acc_q[3]) + yc(br_q[3], 1);
      for (int i = 5; i <= 6; i++) begin
        acc_q[i] <= qmul(acc_q[i-1], x_q[i-1]) + yc(br_q[i-1], i - 3);
      end
      acc_q[7] <= acc_q[6];
      cx_q <= to_field(x_q[NStg-1]);
      cy_q <= to_field(acc_q[NStg-1]);
    end
  end

  assign out_valid_o = ov_q;
  assign chroma_x_o = cx_q;
  assign chroma_y_o = cy_q;
endmodule

// File: rtl/core/m2xy_checker.sv
// Port-level checker for the Planckian locus block, bound to the top level.
`timescale 1ns / 1ps
`include "mireds_to_xy_planckian_locus_defines.svh"
module m2xy_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] chroma_x_o,
  input logic [15:0] chroma_y_o
);
  `M2XY_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(chroma_x_o) && $stable(chroma_y_o),
                    "stalled result changed")
  `M2XY_ASSERT(a_x_range, out_valid_o, chroma_x_o <= 16'hFEFF, "chroma x beyond saturation")
  `M2XY_ASSERT(a_y_range, out_valid_o, chroma_y_o <= 16'hFEFF, "chroma y beyond saturation")
  `M2XY_ASSERT(a_known, out_valid_o, !$isunknown(chroma_x_o) && !$isunknown(chroma_y_o),
               "result carries unknown bits")
  `M2XY_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i,
                    "input valid dropped before its transfer")
endmodule

bind mireds_to_xy_planckian_locus m2xy_checker u_checker (.*);

// File: dv/tb_mireds_to_xy_planckian_locus.sv
// Self-checking testbench for the mireds to Planckian locus xy converter.
`timescale 1ns / 1ps
module tb_mireds_to_xy_planckian_locus;
  import m2xy_pkg::*;

  localparam int unsigned FracBits = 24;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned CycleLimit = 200000;

  typedef longint coef_set_t [4];
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } xy_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] temp_mireds_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] chroma_x_o;
  logic [15:0] chroma_y_o;

  xy_t         locus_q[$];
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned burst_left = 0;
  logic        stall_on = 1'b0;
  logic [15:0] stall_pattern = 16'hFFFF;

  mireds_to_xy_planckian_locus #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .temp_mireds_i,
    .out_valid_o, .out_ready_i, .chroma_x_o, .chroma_y_o
  );

  always #5 clk_i = ~clk_i;

  // Coefficient in units of 1e-9 to Q format, halves rounded away from zero.
  function automatic longint to_q(input longint c);
    longint mag;
    longint r;
    mag = (c < 0) ? -c : c;
    r = ((mag << FracBits) + 64'sd500000000) / 64'sd1000000000;
    return (c < 0) ? -r : r;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    longint unsigned p;
    longint r;
    p = longint'((a < 0) ? -a : a) * longint'((b < 0) ? -b : b);
    r = longint'((p + (64'd1 << (FracBits - 1))) >> FracBits);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint horner(input coef_set_t c, input longint v);
    longint acc;
    acc = to_q(c[0]);
    for (int i = 1; i < 4; i++) acc = q_mul(acc, v) + to_q(c[i]);
    return acc;
  endfunction

  function automatic logic [15:0] saturate_coord(input longint q);
    longint u;
    if (q <= 0) return 16'd0;
    u = q >>> (FracBits - 16);
    return (u > longint'(XyMax)) ? XyMax : u[15:0];
  endfunction

  function automatic xy_t predict_xy(input logic [15:0] mireds);
    coef_set_t x_warm, x_cool, y_low, y_mid, y_high;
    longint m, s, x, y;
    branch_e br;
    xy_t r;
    x_warm = '{-266123900, -234358900, 877695600, 179910000};
    x_cool = '{-64'sd3025846900, 2107037900, 222634700, 240390000};
    y_low  = '{-1106381400, -1348110200, 64'sd2185558320, -202196830};
    y_mid  = '{-954947600, -1374185930, 2091370150, -167488670};
    y_high = '{64'sd3081758000, -64'sd5873386700, 64'sd3751129970, -370014830};
    m = mireds;
    if (m < MiredsLo) m = MiredsLo;
    // Cooler than 1667 K pins s to 1000/1667.
    if (m > MiredsHi) s = ((64'sd1000 << FracBits) + 833) / 1667;
    else s = ((m << FracBits) + 500) / 1000;
    x = (m >= Split4000K) ? horner(x_warm, s) : horner(x_cool, s);
    if (m >= Split2222K) br = BR_LOW;
    else if (m >= Split4000K) br = BR_MID;
    else br = BR_HIGH;
    case (br)
      BR_LOW:  y = horner(y_low, x);
      BR_MID:  y = horner(y_mid, x);
      default: y = horner(y_high, x);
    endcase
    r.x = saturate_coord(x);
    r.y = saturate_coord(y);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  // Sends one item, holding valid through bursts and idling between them.
  task automatic send_mireds(input logic [15:0] mireds);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid_i = 1'b1;
    temp_mireds_i = mireds;
    do @(posedge clk_i); while (!in_ready_o);
    locus_q.push_back(predict_xy(mireds));
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (locus_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [15:0] pts[$];
    pts = '{16'd0, 16'd1, 16'd39, 16'd40, 16'd41, 16'd100, 16'd249, 16'd250, 16'd251,
            16'd300, 16'd450, 16'd451, 16'd452, 16'd598, 16'd599, 16'd600, 16'd601,
            16'd1000, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'hFFFE, 16'hFFFF};
    foreach (pts[i]) send_mireds(pts[i]);
  endtask

  // Mostly inside the clamp range, weighted towards the clamp limits and the branch splits.
  task automatic test_random_locus();
    int unsigned sel;
    int unsigned edge_pt;
    repeat (600) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        case ($urandom_range(0, 3))
          0: edge_pt = MiredsLo;
          1: edge_pt = Split4000K;
          2: edge_pt = Split2222K;
          default: edge_pt = MiredsHi;
        endcase
        send_mireds(16'(edge_pt + $urandom_range(0, 4) - 2));
      end else begin
        send_mireds(16'($urandom_range(0, 700)));
      end
    end
  endtask

  task automatic test_random_full();
    repeat (400) send_mireds(16'($urandom_range(0, 65535)));
  endtask

  // Receiver stalls on a rotating pattern that is renewed now and then.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) begin
      stall_on <= ($urandom_range(0, 3) != 0);
      stall_pattern <= 16'($urandom);
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    out_ready_i <= stall_on ? stall_pattern[0] : 1'b1;
  end

  always @(posedge clk_i) begin
    xy_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (locus_q.size() == 0) begin
        $display("UNEXPECTED transfer x=%h y=%h at cycle %0d", chroma_x_o, chroma_y_o,
                 n_cycles);
        n_errors++;
      end else begin
        want = locus_q.pop_front();
        if (chroma_x_o !== want.x) report_mismatch("chroma_x", chroma_x_o, want.x);
        if (chroma_y_o !== want.y) report_mismatch("chroma_y", chroma_y_o, want.y);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    wait_drained();
    test_random_locus();
    wait_drained();
    test_random_full();
    wait_drained();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: mireds_to_xy_planckian_locus.f
+incdir+rtl/core
rtl/core/m2xy_pkg.sv
rtl/core/m2xy_front.sv
rtl/core/m2xy_fifo.sv
rtl/core/m2xy_back.sv
rtl/core/mireds_to_xy_planckian_locus.sv
rtl/core/m2xy_checker.sv
dv/tb_mireds_to_xy_planckian_locus.sv
